FILE: sv/stt_pkg.sv
package stt_pkg;

  // field widths
  localparam int unsigned LineBits   = 16;
  localparam int unsigned ColBits    = 16;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned LengthBits = 16;
  localparam int unsigned KindBits   = 5;

  typedef logic [LineBits-1:0]   line_t;
  typedef logic [ColBits-1:0]    col_t;
  typedef logic [OffsetBits-1:0] offset_t;
  typedef logic [LengthBits-1:0] length_t;

  // character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChUnder = 8'h5F;

  typedef enum logic [KindBits-1:0] {
    TK_ILLEGAL  = 5'd0,
    TK_EOF      = 5'd1,
    TK_IDENT    = 5'd2,
    TK_INT      = 5'd3,
    TK_DOUBLE   = 5'd4,
    TK_ASSIGN   = 5'd5,
    TK_EQ       = 5'd6,
    TK_BANG     = 5'd7,
    TK_NOT_EQ   = 5'd8,
    TK_PLUS     = 5'd9,
    TK_MINUS    = 5'd10,
    TK_ASTERISK = 5'd11,
    TK_SLASH    = 5'd12,
    TK_MODULO   = 5'd13,
    TK_SEMI     = 5'd14,
    TK_LPAREN   = 5'd15,
    TK_RPAREN   = 5'd16,
    TK_COMMA    = 5'd17,
    TK_LBRACE   = 5'd18,
    TK_RBRACE   = 5'd19,
    TK_LT       = 5'd20,
    TK_GT       = 5'd21
  } token_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUM    = 3'd2,
    MODE_NUMDOT = 3'd3,
    MODE_EQ     = 3'd4,
    MODE_BANG   = 3'd5
  } scan_mode_e;

  typedef struct packed {
    token_kind_e kind;
    line_t       line;
    col_t        col;
    offset_t     offset;
    length_t     len;
    logic        last;
  } tok_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == ChUnder);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

  // kind of a byte that forms a token on its own
  function automatic token_kind_e single_kind(logic [7:0] c);
    token_kind_e k;
    unique case (c)
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_ASTERISK;
      8'h2F:   k = TK_SLASH;
      8'h25:   k = TK_MODULO;
      8'h3B:   k = TK_SEMI;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h2C:   k = TK_COMMA;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h3C:   k = TK_LT;
      8'h3E:   k = TK_GT;
      default: k = TK_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(token_kind_e kind, line_t line, col_t col,
                                  offset_t offset, length_t len);
    tok_t t;
    t.kind   = kind;
    t.line   = line;
    t.col    = col;
    t.offset = offset;
    t.len    = len;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

FILE: sv/stt_char_if.sv
interface stt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

FILE: sv/stt_tok_if.sv
interface stt_tok_if;
  logic                             valid;
  logic                             ready;
  logic [stt_pkg::KindBits-1:0]     token_kind;
  logic [stt_pkg::LineBits-1:0]     start_line;
  logic [stt_pkg::ColBits-1:0]      start_col;
  logic [stt_pkg::OffsetBits-1:0]   start_offset;
  logic [stt_pkg::LengthBits-1:0]   token_length;
  logic                             last_of_run;

  modport source (output valid, token_kind, start_line, start_col, start_offset,
                  token_length, last_of_run, input ready);
  modport sink   (input valid, token_kind, start_line, start_col, start_offset,
                  token_length, last_of_run, output ready);
endinterface

FILE: sv/source_text_tokenizer.sv
// channel  | dir | modport | payload
// txt_i    | in  | sink    | char_code, end_of_text
// tok_o    | out | source  | token_kind, start_line, start_col, start_offset,
//          |     |         | token_length, last_of_run
//
// a byte lands in an input register, is scanned and its (zero to three)
// tokens go into a three-entry result queue drained one per cycle while
// tok_o is ready, so one byte per cycle if each yields at most one token;
// else the next byte waits in the input register until the queue drains
// the input register takes a new byte while results still wait on tok_o
// rst_ni clears the scanner to line 1, column 1, offset 0, no pending token
module source_text_tokenizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  stt_char_if.sink       txt_i,
  stt_tok_if.source      tok_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_end_q;

  // scanner state
  stt_pkg::scan_mode_e mode_q, mode_d;
  stt_pkg::line_t      line_q, line_d, tsl_q, tsl_d;
  stt_pkg::col_t       col_q, col_d, tsc_q, tsc_d;
  stt_pkg::offset_t    off_q, off_d, tso_q, tso_d;
  stt_pkg::length_t    run_q, run_d;
  logic                seen_q, seen_d;

  // result queue
  stt_pkg::tok_t slot_q [3];
  stt_pkg::tok_t slot_d [3];
  logic [1:0]    cnt_q, cnt_d;

  logic          in_xfer, out_xfer, buf_free, proc;
  logic          is_end, absorbed;
  logic [7:0]    ce;
  logic          v_a, v_b, v_c;
  stt_pkg::tok_t tok_a, tok_b, tok_c;
  stt_pkg::length_t run_inc, run_inc2;
  stt_pkg::col_t    col_back;
  stt_pkg::offset_t off_back;

  // handshakes
  assign out_xfer    = tok_o.valid && tok_o.ready;
  assign buf_free    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_xfer);
  assign proc        = in_vld_q && buf_free;
  assign txt_i.ready = !in_vld_q || proc;
  assign in_xfer     = txt_i.valid && txt_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  // saturating helpers
  assign is_end   = in_end_q || (in_char_q == stt_pkg::ChNul);
  assign ce       = is_end ? stt_pkg::ChNul : in_char_q;
  assign run_inc  = (run_q == '1) ? run_q : run_q + 1'b1;
  assign run_inc2 = (run_inc == '1) ? run_inc : run_inc + 1'b1;
  assign col_back = ((col_q == '1) || (col_q == '0)) ? col_q : col_q - 1'b1;
  assign off_back = ((off_q == '1) || (off_q == '0)) ? off_q : off_q - 1'b1;

  // scan one byte: resolve the pending token, then start a new one
  always_comb begin
    mode_d   = stt_pkg::MODE_IDLE;
    run_d    = run_q;
    seen_d   = seen_q;
    tsl_d    = tsl_q;
    tsc_d    = tsc_q;
    tso_d    = tso_q;
    absorbed = 1'b0;
    v_a      = 1'b0;
    v_b      = 1'b0;
    v_c      = 1'b0;
    tok_a    = '0;
    tok_b    = '0;
    tok_c    = '0;

    unique case (mode_q)
      stt_pkg::MODE_IDENT: begin
        if (stt_pkg::is_alpha(ce)) begin
          mode_d   = stt_pkg::MODE_IDENT;
          run_d    = run_inc;
          absorbed = 1'b1;
        end else begin
          v_a   = 1'b1;
          tok_a = stt_pkg::mk_tok(stt_pkg::TK_IDENT, tsl_q, tsc_q, tso_q, run_q);
        end
      end
      stt_pkg::MODE_NUM: begin
        if (stt_pkg::is_digit(ce)) begin
          mode_d   = stt_pkg::MODE_NUM;
          run_d    = run_inc;
          absorbed = 1'b1;
        end else if ((ce == stt_pkg::ChDot) && !seen_q) begin
          mode_d   = stt_pkg::MODE_NUMDOT;
          absorbed = 1'b1;
        end else begin
          v_a   = 1'b1;
          tok_a = stt_pkg::mk_tok(seen_q ? stt_pkg::TK_DOUBLE : stt_pkg::TK_INT,
                                  tsl_q, tsc_q, tso_q, run_q);
        end
      end
      stt_pkg::MODE_NUMDOT: begin
        if (stt_pkg::is_digit(ce)) begin
          mode_d   = stt_pkg::MODE_NUM;
          seen_d   = 1'b1;
          run_d    = run_inc2;
          absorbed = 1'b1;
        end else begin
          // number without its dot, then the dot on its own
          v_a   = 1'b1;
          tok_a = stt_pkg::mk_tok(stt_pkg::TK_INT, tsl_q, tsc_q, tso_q, run_q);
          v_b   = 1'b1;
          tok_b = stt_pkg::mk_tok(stt_pkg::TK_ILLEGAL, line_q, col_back, off_back,
                                  stt_pkg::length_t'(1));
        end
      end
      stt_pkg::MODE_EQ: begin
        v_a = 1'b1;
        if (ce == stt_pkg::ChEq) begin
          absorbed = 1'b1;
          tok_a = stt_pkg::mk_tok(stt_pkg::TK_EQ, tsl_q, tsc_q, tso_q,
                                  stt_pkg::length_t'(2));
        end else begin
          tok_a = stt_pkg::mk_tok(stt_pkg::TK_ASSIGN, tsl_q, tsc_q, tso_q,
                                  stt_pkg::length_t'(1));
        end
      end
      stt_pkg::MODE_BANG: begin
        v_a = 1'b1;
        if (ce == stt_pkg::ChEq) begin
          absorbed = 1'b1;
          tok_a = stt_pkg::mk_tok(stt_pkg::TK_NOT_EQ, tsl_q, tsc_q, tso_q,
                                  stt_pkg::length_t'(2));
        end else begin
          tok_a = stt_pkg::mk_tok(stt_pkg::TK_BANG, tsl_q, tsc_q, tso_q,
                                  stt_pkg::length_t'(1));
        end
      end
      default: begin
      end
    endcase

    if (is_end) begin
      // flush then end token at the current position
      v_c    = 1'b1;
      tok_c  = stt_pkg::mk_tok(stt_pkg::TK_EOF, line_q, col_q, off_q, '0);
      mode_d = stt_pkg::MODE_IDLE;
      run_d  = '0;
      seen_d = 1'b0;
    end else if (!absorbed) begin
      priority if (stt_pkg::is_space(ce)) begin
      end else if (stt_pkg::is_alpha(ce) || stt_pkg::is_digit(ce) ||
                   (ce == stt_pkg::ChEq) || (ce == stt_pkg::ChBang)) begin
        tsl_d  = line_q;
        tsc_d  = col_q;
        tso_d  = off_q;
        run_d  = stt_pkg::length_t'(1);
        seen_d = 1'b0;
        priority if (stt_pkg::is_alpha(ce)) begin
          mode_d = stt_pkg::MODE_IDENT;
        end else if (stt_pkg::is_digit(ce)) begin
          mode_d = stt_pkg::MODE_NUM;
        end else if (ce == stt_pkg::ChEq) begin
          mode_d = stt_pkg::MODE_EQ;
        end else begin
          mode_d = stt_pkg::MODE_BANG;
        end
      end else begin
        v_c   = 1'b1;
        tok_c = stt_pkg::mk_tok(stt_pkg::single_kind(ce), line_q, col_q, off_q,
                                stt_pkg::length_t'(1));
      end
    end
  end

  // position update
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    off_d  = off_q;
    if (!is_end) begin
      if (ce == stt_pkg::ChLf) begin
        line_d = (line_q == '1) ? line_q : line_q + 1'b1;
        col_d  = stt_pkg::col_t'(1);
      end else begin
        col_d  = (col_q == '1) ? col_q : col_q + 1'b1;
      end
      off_d = (off_q == '1) ? off_q : off_q + 1'b1;
    end
  end

  // result queue: load compacted tokens or shift on transfer
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (proc) begin
      cnt_d     = 2'(v_a) + 2'(v_b) + 2'(v_c);
      slot_d[0] = v_a ? tok_a : tok_c;
      slot_d[1] = v_b ? tok_b : tok_c;
      slot_d[2] = tok_c;
      slot_d[0].last = (cnt_d == 2'd1);
      slot_d[1].last = (cnt_d == 2'd2);
      slot_d[2].last = (cnt_d == 2'd3);
    end else if (out_xfer) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
      mode_q   <= stt_pkg::MODE_IDLE;
      line_q   <= stt_pkg::line_t'(1);
      col_q    <= stt_pkg::col_t'(1);
      off_q    <= '0;
      tsl_q    <= stt_pkg::line_t'(1);
      tsc_q    <= stt_pkg::col_t'(1);
      tso_q    <= '0;
      run_q    <= '0;
      seen_q   <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      cnt_q    <= cnt_d;
      if (proc) begin
        mode_q <= mode_d;
        line_q <= line_d;
        col_q  <= col_d;
        off_q  <= off_d;
        tsl_q  <= tsl_d;
        tsc_q  <= tsc_d;
        tso_q  <= tso_d;
        run_q  <= run_d;
        seen_q <= seen_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_char_q <= txt_i.char_code;
      in_end_q  <= txt_i.end_of_text;
    end
    slot_q <= slot_d;
  end

  // output port
  assign tok_o.valid        = (cnt_q != 2'd0);
  assign tok_o.token_kind   = slot_q[0].kind;
  assign tok_o.start_line   = slot_q[0].line;
  assign tok_o.start_col    = slot_q[0].col;
  assign tok_o.start_offset = slot_q[0].offset;
  assign tok_o.token_length = slot_q[0].len;
  assign tok_o.last_of_run  = slot_q[0].last;

  // the final queued result of a byte carries the last marker
  a_last_marked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && (cnt_q == 2'd1)) |-> tok_o.last_of_run)
    else $error("last queued token not marked last");

  // a held byte is scanned as soon as the queue is empty
  a_no_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && (cnt_q == 2'd0)) |-> proc)
    else $error("byte held with an empty result queue");

  // end of text always leaves the scanner idle with an end token queued
  a_end_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && is_end) |=> ((mode_q == stt_pkg::MODE_IDLE) && (cnt_q != 2'd0)))
    else $error("end of text did not flush");

  // columns and lines count from one
  a_pos_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q != '0) && (line_q != '0))
    else $error("position counter reached zero");

endmodule

FILE: bench/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps

module source_text_tokenizer_tb;

  localparam int RandomItems = 185;
  localparam int IdleLimit   = 1000;
  localparam int LongHold    = 40;
  localparam int DrainCycles = 20;

  localparam longint unsigned LineTop   = (64'd1 << stt_pkg::LineBits) - 1;
  localparam longint unsigned ColTop    = (64'd1 << stt_pkg::ColBits) - 1;
  localparam longint unsigned OffsetTop = (64'd1 << stt_pkg::OffsetBits) - 1;
  localparam longint unsigned LengthTop = (64'd1 << stt_pkg::LengthBits) - 1;

  localparam stt_pkg::tok_t NoTok = '0;

  typedef struct packed {
    logic [7:0]    code;
    logic          eot;
    logic          typed;
    stt_pkg::tok_t want;
  } text_row_t;

  logic clk_i;
  logic rst_ni;

  stt_char_if txt_bus ();
  stt_tok_if  tok_bus ();

  source_text_tokenizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .txt_i  (txt_bus),
    .tok_o  (tok_bus)
  );

  // scanner state mirrored by the predictor
  stt_pkg::scan_mode_e scan_state;
  stt_pkg::line_t      cur_line;
  stt_pkg::col_t       cur_col;
  stt_pkg::offset_t    cur_off;
  stt_pkg::line_t      start_line;
  stt_pkg::col_t       start_col;
  stt_pkg::offset_t    start_off;
  stt_pkg::length_t    run_len;
  logic                seen_dot;

  stt_pkg::tok_t step_tokens[$];
  stt_pkg::tok_t awaited_tokens[$];

  logic          row_typed;
  stt_pkg::tok_t row_expect;
  logic          no_gaps;
  logic          hold_req;
  int            bytes_sent;
  int            errors;

  logic [7:0] op_chars [13] = '{"+", "-", "*", "/", "%", ";", "(", ")", ",", "{", "}",
                                "<", ">"};
  logic [7:0] space_chars [4] = '{stt_pkg::ChSpace, stt_pkg::ChTab, stt_pkg::ChLf,
                                  stt_pkg::ChCr};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned sat_up(longint unsigned v, longint unsigned top);
    return (v >= top) ? v : v + 1;
  endfunction

  function automatic longint unsigned step_back(longint unsigned v, longint unsigned top);
    return (v >= top || v == 0) ? v : v - 1;
  endfunction

  function automatic logic letter_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == stt_pkg::ChUnder;
  endfunction

  function automatic logic digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic stt_pkg::token_kind_e operator_kind(logic [7:0] c);
    case (c)
      "+":     return stt_pkg::TK_PLUS;
      "-":     return stt_pkg::TK_MINUS;
      "*":     return stt_pkg::TK_ASTERISK;
      "/":     return stt_pkg::TK_SLASH;
      "%":     return stt_pkg::TK_MODULO;
      ";":     return stt_pkg::TK_SEMI;
      "(":     return stt_pkg::TK_LPAREN;
      ")":     return stt_pkg::TK_RPAREN;
      ",":     return stt_pkg::TK_COMMA;
      "{":     return stt_pkg::TK_LBRACE;
      "}":     return stt_pkg::TK_RBRACE;
      "<":     return stt_pkg::TK_LT;
      ">":     return stt_pkg::TK_GT;
      default: return stt_pkg::TK_ILLEGAL;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return stt_pkg::ChUnder;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic add_token(stt_pkg::token_kind_e kind, longint unsigned ln,
                           longint unsigned col, longint unsigned off,
                           longint unsigned len);
    stt_pkg::tok_t t;
    t.kind   = kind;
    t.line   = stt_pkg::line_t'(ln);
    t.col    = stt_pkg::col_t'(col);
    t.offset = stt_pkg::offset_t'(off);
    t.len    = stt_pkg::length_t'(len);
    t.last   = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic open_token(stt_pkg::scan_mode_e m);
    scan_state = m;
    start_line = cur_line;
    start_col  = cur_col;
    start_off  = cur_off;
    run_len    = stt_pkg::length_t'(1);
    seen_dot   = 1'b0;
  endtask

  // tokens that one text byte (or an end marker) completes
  task automatic scan_byte(input logic [7:0] code, input logic eot);
    logic [7:0]          c;
    logic                eof;
    logic                taken;
    stt_pkg::scan_mode_e was;
    eof   = eot || code == stt_pkg::ChNul;
    c     = eof ? stt_pkg::ChNul : code;
    taken = 1'b0;
    was   = scan_state;
    scan_state = stt_pkg::MODE_IDLE;
    step_tokens.delete();

    // settle the pending token against this byte
    case (was)
      stt_pkg::MODE_IDENT: begin
        if (letter_byte(c)) begin
          scan_state = stt_pkg::MODE_IDENT;
          run_len    = stt_pkg::length_t'(sat_up(run_len, LengthTop));
          taken      = 1'b1;
        end else begin
          add_token(stt_pkg::TK_IDENT, start_line, start_col, start_off, run_len);
        end
      end
      stt_pkg::MODE_NUM: begin
        if (digit_byte(c)) begin
          scan_state = stt_pkg::MODE_NUM;
          run_len    = stt_pkg::length_t'(sat_up(run_len, LengthTop));
          taken      = 1'b1;
        end else if (c == stt_pkg::ChDot && !seen_dot) begin
          scan_state = stt_pkg::MODE_NUMDOT;
          taken      = 1'b1;
        end else begin
          add_token(seen_dot ? stt_pkg::TK_DOUBLE : stt_pkg::TK_INT, start_line, start_col,
                    start_off, run_len);
        end
      end
      stt_pkg::MODE_NUMDOT: begin
        if (digit_byte(c)) begin
          scan_state = stt_pkg::MODE_NUM;
          seen_dot   = 1'b1;
          run_len    = stt_pkg::length_t'(sat_up(sat_up(run_len, LengthTop), LengthTop));
          taken      = 1'b1;
        end else begin
          // the held dot falls out as a stray byte just before this one
          add_token(stt_pkg::TK_INT, start_line, start_col, start_off, run_len);
          add_token(stt_pkg::TK_ILLEGAL, cur_line, step_back(cur_col, ColTop),
                    step_back(cur_off, OffsetTop), 1);
        end
      end
      stt_pkg::MODE_EQ: begin
        if (c == stt_pkg::ChEq) begin
          add_token(stt_pkg::TK_EQ, start_line, start_col, start_off, 2);
          taken = 1'b1;
        end else begin
          add_token(stt_pkg::TK_ASSIGN, start_line, start_col, start_off, 1);
        end
      end
      stt_pkg::MODE_BANG: begin
        if (c == stt_pkg::ChEq) begin
          add_token(stt_pkg::TK_NOT_EQ, start_line, start_col, start_off, 2);
          taken = 1'b1;
        end else begin
          add_token(stt_pkg::TK_BANG, start_line, start_col, start_off, 1);
        end
      end
      default: ;
    endcase

    if (eof) begin
      add_token(stt_pkg::TK_EOF, cur_line, cur_col, cur_off, 0);
      scan_state = stt_pkg::MODE_IDLE;
      run_len    = '0;
      seen_dot   = 1'b0;
    end else begin
      // a byte not absorbed above starts something new
      if (!taken) begin
        if (c == stt_pkg::ChSpace || c == stt_pkg::ChTab || c == stt_pkg::ChLf ||
            c == stt_pkg::ChCr) begin
        end else if (letter_byte(c)) begin
          open_token(stt_pkg::MODE_IDENT);
        end else if (digit_byte(c)) begin
          open_token(stt_pkg::MODE_NUM);
        end else if (c == stt_pkg::ChEq) begin
          open_token(stt_pkg::MODE_EQ);
        end else if (c == stt_pkg::ChBang) begin
          open_token(stt_pkg::MODE_BANG);
        end else begin
          add_token(operator_kind(c), cur_line, cur_col, cur_off, 1);
        end
      end
      // advance the position
      if (c == stt_pkg::ChLf) begin
        cur_line = stt_pkg::line_t'(sat_up(cur_line, LineTop));
        cur_col  = stt_pkg::col_t'(1);
      end else begin
        cur_col = stt_pkg::col_t'(sat_up(cur_col, ColTop));
      end
      cur_off = stt_pkg::offset_t'(sat_up(cur_off, OffsetTop));
    end

    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // one byte transfer on the text channel; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] code, input logic eot);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      txt_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    txt_bus.char_code   = code;
    txt_bus.end_of_text = eot;
    txt_bus.valid       = 1'b1;
    do @(posedge clk_i); while (txt_bus.ready !== 1'b1);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    txt_bus.valid = 1'b0;
    while (awaited_tokens.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // check token transfers, predict on byte transfers
  always @(posedge clk_i) begin : port_monitor
    stt_pkg::tok_t want;
    if (tok_bus.valid && tok_bus.ready) begin
      if (awaited_tokens.size() == 0) begin
        report_mismatch("token_kind of an unexpected token", tok_bus.token_kind, 0);
      end else begin
        want = awaited_tokens.pop_front();
        if (tok_bus.token_kind !== want.kind)
          report_mismatch("token_kind", tok_bus.token_kind, want.kind);
        if (tok_bus.start_line !== want.line)
          report_mismatch("start_line", tok_bus.start_line, want.line);
        if (tok_bus.start_col !== want.col)
          report_mismatch("start_col", tok_bus.start_col, want.col);
        if (tok_bus.start_offset !== want.offset)
          report_mismatch("start_offset", tok_bus.start_offset, want.offset);
        if (tok_bus.token_length !== want.len)
          report_mismatch("token_length", tok_bus.token_length, want.len);
        if (tok_bus.last_of_run !== want.last)
          report_mismatch("last_of_run", tok_bus.last_of_run, want.last);
      end
    end
    if (txt_bus.valid && txt_bus.ready) begin
      scan_byte(txt_bus.char_code, txt_bus.end_of_text);
      if (row_typed) begin
        awaited_tokens.push_back(row_expect);
      end else begin
        foreach (step_tokens[i]) awaited_tokens.push_back(step_tokens[i]);
      end
    end
  end

  // token receiver: random stalls per transfer, one long hold on request
  initial begin : token_sink
    int   stall;
    logic held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        tok_bus.ready = 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        tok_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      tok_bus.ready = 1'b1;
      do @(posedge clk_i); while (tok_bus.valid !== 1'b1);
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((txt_bus.valid && txt_bus.ready) || (tok_bus.valid && tok_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("[source_text_tokenizer] ERROR");
    $finish;
  end

  initial begin : stimulus
    text_row_t  script [28];
    int         start;
    logic       hold_done;
    logic       paused;
    logic [7:0] b;

    rst_ni              = 1'b0;
    txt_bus.valid       = 1'b0;
    txt_bus.char_code   = '0;
    txt_bus.end_of_text = 1'b0;
    tok_bus.ready       = 1'b0;
    row_typed           = 1'b0;
    row_expect          = NoTok;
    no_gaps             = 1'b0;
    hold_req            = 1'b0;
    bytes_sent          = 0;
    errors              = 0;
    hold_done           = 1'b0;
    paused              = 1'b0;

    scan_state = stt_pkg::MODE_IDLE;
    cur_line   = stt_pkg::line_t'(1);
    cur_col    = stt_pkg::col_t'(1);
    cur_off    = '0;
    start_line = stt_pkg::line_t'(1);
    start_col  = stt_pkg::col_t'(1);
    start_off  = '0;
    run_len    = '0;
    seen_dot   = 1'b0;

    // directed text: operators, top bytes, end markers, pairing, the waiting dot
    script = '{
      '{"+",   1'b0, 1'b1, '{stt_pkg::TK_PLUS,    16'd1, 16'd1, 32'd0, 16'd1, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{stt_pkg::TK_ILLEGAL, 16'd1, 16'd2, 32'd1, 16'd1, 1'b1}},
      '{8'h80, 1'b0, 1'b1, '{stt_pkg::TK_ILLEGAL, 16'd1, 16'd3, 32'd2, 16'd1, 1'b1}},
      '{8'hA5, 1'b1, 1'b1, '{stt_pkg::TK_EOF,     16'd1, 16'd4, 32'd3, 16'd0, 1'b1}},
      '{"a",              1'b0, 1'b0, NoTok},
      '{"Z",              1'b0, 1'b0, NoTok},
      '{stt_pkg::ChUnder, 1'b0, 1'b0, NoTok},
      '{"0",              1'b0, 1'b0, NoTok},
      '{stt_pkg::ChDot,   1'b0, 1'b0, NoTok},
      '{"9",              1'b0, 1'b0, NoTok},
      '{stt_pkg::ChDot,   1'b0, 1'b0, NoTok},
      '{"7",              1'b0, 1'b0, NoTok},
      '{stt_pkg::ChDot,   1'b0, 1'b0, NoTok},
      '{"-",              1'b0, 1'b0, NoTok},
      '{stt_pkg::ChEq,    1'b0, 1'b0, NoTok},
      '{stt_pkg::ChEq,    1'b0, 1'b0, NoTok},
      '{stt_pkg::ChBang,  1'b0, 1'b0, NoTok},
      '{stt_pkg::ChEq,    1'b0, 1'b0, NoTok},
      '{stt_pkg::ChEq,    1'b0, 1'b0, NoTok},
      '{stt_pkg::ChTab,   1'b0, 1'b0, NoTok},
      '{stt_pkg::ChBang,  1'b0, 1'b0, NoTok},
      '{stt_pkg::ChLf,    1'b0, 1'b0, NoTok},
      '{stt_pkg::ChCr,    1'b0, 1'b0, NoTok},
      '{"4",              1'b0, 1'b0, NoTok},
      '{8'h7F,            1'b0, 1'b0, NoTok},
      '{stt_pkg::ChDot,   1'b0, 1'b0, NoTok},
      '{"3",              1'b0, 1'b0, NoTok},
      '{stt_pkg::ChNul,   1'b0, 1'b0, NoTok}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 28; i++) begin
      row_typed  = script[i].typed;
      row_expect = script[i].want;
      send_byte(script[i].code, script[i].eot);
    end
    row_typed = 1'b0;

    // random text built mostly from well-formed lexemes
    start = bytes_sent;
    while (bytes_sent - start < RandomItems) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      case ($urandom_range(0, 15))
        0, 1, 2, 3: repeat ($urandom_range(1, 6)) send_byte(pick_letter(), 1'b0);
        4, 5, 6: begin
          repeat ($urandom_range(1, 4)) send_byte(pick_digit(), 1'b0);
          if ($urandom_range(0, 1)) begin
            send_byte(stt_pkg::ChDot, 1'b0);
            repeat ($urandom_range(1, 3)) send_byte(pick_digit(), 1'b0);
          end
        end
        7: begin
          send_byte($urandom_range(0, 1) ? stt_pkg::ChEq : stt_pkg::ChBang, 1'b0);
          if ($urandom_range(0, 2) != 0) send_byte(stt_pkg::ChEq, 1'b0);
        end
        8, 9: send_byte(op_chars[$urandom_range(0, 12)], 1'b0);
        10, 11: repeat ($urandom_range(1, 3)) send_byte(space_chars[$urandom_range(0, 3)], 1'b0);
        13: begin
          // number with a dot that no digit follows
          repeat ($urandom_range(1, 3)) send_byte(pick_digit(), 1'b0);
          send_byte(stt_pkg::ChDot, 1'b0);
          case ($urandom_range(0, 3))
            0: b = pick_letter();
            1: b = op_chars[$urandom_range(0, 12)];
            2: b = space_chars[$urandom_range(0, 3)];
            default: b = stt_pkg::ChDot;
          endcase
          send_byte(b, 1'b0);
        end
        14: begin
          if ($urandom_range(0, 1)) send_byte(stt_pkg::ChNul, 1'b0);
          else send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        default: send_byte(8'($urandom_range(0, 255)), 1'b0);
      endcase

      // long receiver hold while single-byte tokens keep arriving
      if (!hold_done && bytes_sent - start >= 60) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (16) send_byte(op_chars[$urandom_range(0, 12)], 1'b0);
      end
      if (!paused && bytes_sent - start >= 140) begin
        paused = 1'b1;
        wait_for_drain();
      end
    end

    // a waiting dot before an operator, then a short tail closed by an end marker
    wait_for_drain();
    no_gaps = 1'b1;
    send_byte(stt_pkg::ChLf, 1'b0);
    send_byte("1", 1'b0);
    send_byte(stt_pkg::ChDot, 1'b0);
    send_byte("+", 1'b0);
    send_byte(stt_pkg::ChLf, 1'b0);
    no_gaps = 1'b0;
    send_byte("x", 1'b0);
    send_byte(stt_pkg::ChEq, 1'b0);
    send_byte(";", 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[source_text_tokenizer] OK");
    end else begin
      $display("[source_text_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
